@@ design/adec_pkg.sv @@
`default_nettype none
package adec_pkg;

    localparam int MAX_CLASSES    = 16;
    localparam int EXP_TABLE_BITS = 8;
    localparam int POS_W          = 5;
    localparam int ARG_W          = 4;
    localparam int SUM_W          = 24;
    localparam int EXP_W          = 17;
    localparam int EXP_CNT_W      = 4;
    localparam int DIV_NUM_W      = 34;
    localparam int DIV_DEN_W      = 24;
    localparam int DIV_CNT_W      = 6;

    localparam logic [15:0]      LOG2E_Q15 = 16'd47274;
    localparam logic [17:0]      E_Q16     = 18'd178145;
    localparam logic [16:0]      ONE_Q16   = 17'd65536;
    localparam logic [SUM_W-1:0] SUM_MAX   = 24'hFFFFFF;

    localparam logic CFG_IMG_W = 1'b0;
    localparam logic CFG_IMG_H = 1'b1;

    // 2^(-2^-j) in Q0.30, j = 1..12
    localparam logic [29:0] POW2_FRAC [12] = '{
        30'd759250125, 30'd902905651, 30'd984625594, 30'd1028218693,
        30'd1050733751, 30'd1062175491, 30'd1067942999, 30'd1070838486,
        30'd1072289172, 30'd1073015253, 30'd1073378455, 30'd1073560135
    };

    typedef struct packed {
        logic signed [15:0] conf;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] dw;
        logic signed [15:0] dh;
        logic [15:0]        acx;
        logic [15:0]        acy;
        logic [15:0]        aw;
        logic [15:0]        ah;
        logic [SUM_W-1:0]   exp_sum;
        logic [ARG_W-1:0]   argmax;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage
`default_nettype wire

@@ design/anchor_detection_decode_top.sv @@
`default_nettype none
// channel   direction  handshake          payload
// input     in         i_valid/o_ready    class logit, last mark, conf, deltas, anchor
// result    out        o_valid/i_ready    box centre/size, score, best class
// config    in         i_cfg_we           i_cfg_idx selects width/height, i_cfg_data
//
// Each class transaction in the front is one exp(-d) pass of eight table products
// on a shared multiplier. The last class of an anchor adds a queue push. The back
// works on each anchor through up to two divisions of the score and up to three
// exp(-d) passes; a two-entry queue lets the front run ahead. Reset is synchronous,
// active low, and clears all control.
module anchor_detection_decode_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [15:0] i_class_logit,
    input  wire logic               i_last_class,
    input  wire logic signed [15:0] i_confidence_logit,
    input  wire logic signed [15:0] i_delta_x,
    input  wire logic signed [15:0] i_delta_y,
    input  wire logic signed [15:0] i_delta_w,
    input  wire logic signed [15:0] i_delta_h,
    input  wire logic [15:0]        i_anchor_cx,
    input  wire logic [15:0]        i_anchor_cy,
    input  wire logic [15:0]        i_anchor_w,
    input  wire logic [15:0]        i_anchor_h,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [15:0]             o_box_cx,
    output logic [15:0]             o_box_cy,
    output logic [15:0]             o_box_w,
    output logic [15:0]             o_box_h,
    output logic [15:0]             o_score,
    output logic [3:0]              o_best_class,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [12:0]        i_cfg_data
);
    logic [12:0]        r_img_w;
    logic [12:0]        r_img_h;
    logic               push;
    logic               pop;
    adec_pkg::t_job     push_job;
    adec_pkg::t_job     head_job;
    adec_pkg::t_q_stat  q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= 13'd1248;
            r_img_h <= 13'd384;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                adec_pkg::CFG_IMG_W: r_img_w <= i_cfg_data;
                adec_pkg::CFG_IMG_H: r_img_h <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    adec_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_class_logit      (i_class_logit),
        .i_last_class       (i_last_class),
        .i_confidence_logit (i_confidence_logit),
        .i_delta_x          (i_delta_x),
        .i_delta_y          (i_delta_y),
        .i_delta_w          (i_delta_w),
        .i_delta_h          (i_delta_h),
        .i_anchor_cx        (i_anchor_cx),
        .i_anchor_cy        (i_anchor_cy),
        .i_anchor_w         (i_anchor_w),
        .i_anchor_h         (i_anchor_h),
        .o_push             (push),
        .o_job              (push_job),
        .i_stat             (q_stat)
    );

    adec_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    adec_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (head_job),
        .i_stat       (q_stat),
        .o_pop        (pop),
        .i_img_w      (r_img_w),
        .i_img_h      (r_img_h),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_box_cx     (o_box_cx),
        .o_box_cy     (o_box_cy),
        .o_box_w      (o_box_w),
        .o_box_h      (o_box_h),
        .o_score      (o_score),
        .o_best_class (o_best_class)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("queue pop while empty");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |=> !o_valid)
        else $error("result repeated after transaction");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !pop)
        else $error("new anchor started while result pending");
endmodule
`default_nettype wire

@@ design/adec_exp.sv @@
`default_nettype none
// exp(-d), d in Q5.11, result Q1.16; one table product per cycle
module adec_exp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [15:0]                   i_d,
    output logic                               o_done,
    output logic [adec_pkg::EXP_W-1:0]         o_res
);
    logic                              r_busy;
    logic                              r_done;
    logic [adec_pkg::EXP_CNT_W-1:0]    r_cnt;
    logic [31:0]                       r_t;
    logic [30:0]                       r_r;
    logic [adec_pkg::EXP_W-1:0]        r_res;
    logic [60:0]                       prod;
    logic [5:0]                        n_int;
    logic [30:0]                       shifted;
    logic                              f_bit;

    assign n_int   = r_t[31:26];
    assign shifted = r_r >> (n_int + 6'd14);
    assign f_bit   = r_t[25 - int'(r_cnt)];
    assign prod    = 61'(r_r) * 61'(adec_pkg::POW2_FRAC[r_cnt]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_t    <= 32'(i_d) * 32'(adec_pkg::LOG2E_Q15);
                r_r    <= 31'(1) << 30;
            end else if (r_busy) begin
                if (r_cnt == adec_pkg::EXP_CNT_W'(adec_pkg::EXP_TABLE_BITS)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_res  <= (n_int > 6'd16) ? '0 : shifted[adec_pkg::EXP_W-1:0];
                end else begin
                    if (f_bit) begin
                        r_r <= prod[60:30];
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule
`default_nettype wire

@@ design/adec_div.sv @@
`default_nettype none
// restoring divider, one quotient bit per cycle
module adec_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [adec_pkg::DIV_NUM_W-1:0]  i_num,
    input  wire logic [adec_pkg::DIV_DEN_W-1:0]  i_den,
    output logic                                 o_done,
    output logic [adec_pkg::DIV_NUM_W-1:0]       o_quot
);
    logic                               r_busy;
    logic                               r_done;
    logic [adec_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [adec_pkg::DIV_DEN_W-1:0]     r_rem;
    logic [adec_pkg::DIV_DEN_W-1:0]     r_den;
    logic [adec_pkg::DIV_NUM_W-1:0]     r_q;
    logic [adec_pkg::DIV_DEN_W:0]       rem_sh;
    logic [adec_pkg::DIV_DEN_W:0]       rem_sub;
    logic                               fits;

    assign rem_sh  = {r_rem, r_q[adec_pkg::DIV_NUM_W-1]};
    assign fits    = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_den  <= i_den;
                r_q    <= i_num;
            end else if (r_busy) begin
                r_rem <= fits ? rem_sub[adec_pkg::DIV_DEN_W-1:0]
                              : rem_sh[adec_pkg::DIV_DEN_W-1:0];
                r_q   <= {r_q[adec_pkg::DIV_NUM_W-2:0], fits};
                if (r_cnt == adec_pkg::DIV_CNT_W'(adec_pkg::DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

@@ design/adec_fifo.sv @@
`default_nettype none
module adec_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire adec_pkg::t_job  i_job,
    input  wire logic            i_pop,
    output adec_pkg::t_job       o_job,
    output adec_pkg::t_q_stat    o_stat
);
    adec_pkg::t_job r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_job        = r_mem[r_rp];
    assign o_stat.full  = r_cnt == 2'd2;
    assign o_stat.empty = r_cnt == 2'd0;
endmodule
`default_nettype wire

@@ design/adec_front.sv @@
`default_nettype none
// online softmax over the class logits; hands finished anchors to the queue
module adec_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [15:0] i_class_logit,
    input  wire logic               i_last_class,
    input  wire logic signed [15:0] i_confidence_logit,
    input  wire logic signed [15:0] i_delta_x,
    input  wire logic signed [15:0] i_delta_y,
    input  wire logic signed [15:0] i_delta_w,
    input  wire logic signed [15:0] i_delta_h,
    input  wire logic [15:0]        i_anchor_cx,
    input  wire logic [15:0]        i_anchor_cy,
    input  wire logic [15:0]        i_anchor_w,
    input  wire logic [15:0]        i_anchor_h,
    output logic                    o_push,
    output adec_pkg::t_job          o_job,
    input  wire adec_pkg::t_q_stat  i_stat
);
    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_EXP  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]                        r_state;
    logic signed [15:0]                r_max;
    logic signed [15:0]                r_x;
    logic [adec_pkg::SUM_W-1:0]        r_sum;
    logic [adec_pkg::ARG_W-1:0]        r_arg;
    logic [adec_pkg::POS_W-1:0]        r_pos;
    logic                              r_gt;
    logic                              r_last;
    adec_pkg::t_job                    r_job;

    logic                              accept;
    logic signed [16:0]                diff;
    logic                              gt;
    logic [15:0]                       d_mag;
    logic                              exp_done;
    logic [adec_pkg::EXP_W-1:0]        exp_res;
    logic [40:0]                       scaled;
    logic [25:0]                       sum_wide;
    logic [adec_pkg::SUM_W-1:0]        sum_new;

    assign o_ready = r_state == F_IDLE;
    assign accept  = i_valid && o_ready;
    assign diff    = 17'(i_class_logit) - 17'(r_max);
    assign gt      = i_class_logit > r_max;
    assign d_mag   = gt ? diff[15:0] : 16'(-diff);

    adec_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_d     (d_mag),
        .o_done  (exp_done),
        .o_res   (exp_res)
    );

    always_comb begin
        scaled = 41'(r_sum) * 41'(exp_res);
        if (r_gt) begin
            sum_wide = 26'(scaled[40:16]) + 26'(adec_pkg::ONE_Q16);
        end else begin
            sum_wide = 26'(r_sum) + 26'(exp_res);
        end
        sum_new = (sum_wide > 26'(adec_pkg::SUM_MAX)) ? adec_pkg::SUM_MAX
                                                       : sum_wide[adec_pkg::SUM_W-1:0];
    end

    assign o_push = (r_state == F_PUSH) && !i_stat.full;
    assign o_job  = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_max   <= 16'sh8000;
            r_sum   <= '0;
            r_arg   <= '0;
            r_pos   <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_state <= F_EXP;
                    end
                end
                F_EXP: begin
                    if (exp_done) begin
                        if (r_last) begin
                            r_state <= F_PUSH;
                        end else begin
                            r_sum <= sum_new;
                            if (r_gt) begin
                                r_max <= r_x;
                                r_arg <= r_pos[adec_pkg::ARG_W-1:0];
                            end
                            r_pos   <= r_pos + 1'b1;
                            r_state <= F_IDLE;
                        end
                    end
                end
                F_PUSH: begin
                    if (!i_stat.full) begin
                        r_max   <= 16'sh8000;
                        r_sum   <= '0;
                        r_arg   <= '0;
                        r_pos   <= '0;
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x        <= i_class_logit;
            r_gt       <= gt;
            r_last     <= i_last_class ||
                          (r_pos >= adec_pkg::POS_W'(adec_pkg::MAX_CLASSES - 1));
            r_job.conf <= i_confidence_logit;
            r_job.dx   <= i_delta_x;
            r_job.dy   <= i_delta_y;
            r_job.dw   <= i_delta_w;
            r_job.dh   <= i_delta_h;
            r_job.acx  <= i_anchor_cx;
            r_job.acy  <= i_anchor_cy;
            r_job.aw   <= i_anchor_w;
            r_job.ah   <= i_anchor_h;
        end
        if (r_state == F_EXP && exp_done && r_last) begin
            r_job.exp_sum <= sum_new;
            r_job.argmax  <= r_gt ? r_pos[adec_pkg::ARG_W-1:0] : r_arg;
        end
    end
endmodule
`default_nettype wire

@@ design/adec_back.sv @@
`default_nettype none
// score and box decode, one anchor at a time
module adec_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire adec_pkg::t_job     i_job,
    input  wire adec_pkg::t_q_stat  i_stat,
    output logic                    o_pop,
    input  wire logic [12:0]        i_img_w,
    input  wire logic [12:0]        i_img_h,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [15:0]             o_box_cx,
    output logic [15:0]             o_box_cy,
    output logic [15:0]             o_box_w,
    output logic [15:0]             o_box_h,
    output logic [15:0]             o_score,
    output logic [3:0]              o_best_class
);
    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_SEXP = 4'd1;
    localparam logic [3:0] B_SDIV = 4'd2;
    localparam logic [3:0] B_QDIV = 4'd3;
    localparam logic [3:0] B_AXST = 4'd4;
    localparam logic [3:0] B_AXWT = 4'd5;
    localparam logic [3:0] B_AXSF = 4'd6;
    localparam logic [3:0] B_AXSZ = 4'd7;
    localparam logic [3:0] B_AXCL = 4'd8;
    localparam logic [3:0] B_AXSV = 4'd9;
    localparam logic [3:0] B_OUT  = 4'd10;

    logic [3:0]                         r_state;
    adec_pkg::t_job                     r_job;
    logic                               r_ax;
    logic [adec_pkg::EXP_W-1:0]         r_e;
    logic [21:0]                        r_safe;
    logic signed [22:0]                 r_cen;
    logic [21:0]                        r_size;
    logic [17:0]                        r_lo;
    logic [17:0]                        r_hi;
    logic                               r_valid;
    logic [15:0]                        r_bcx;
    logic [15:0]                        r_bcy;
    logic [15:0]                        r_bw;
    logic [15:0]                        r_bh;
    logic [15:0]                        r_score;
    logic [3:0]                         r_cls;

    logic                               exp_start;
    logic [15:0]                        exp_d;
    logic                               exp_done;
    logic [adec_pkg::EXP_W-1:0]         exp_res;
    logic                               div_start;
    logic [adec_pkg::DIV_NUM_W-1:0]     div_num;
    logic [adec_pkg::DIV_DEN_W-1:0]     div_den;
    logic                               div_done;
    logic [adec_pkg::DIV_NUM_W-1:0]     div_quot;

    logic [15:0]                        ax_c;
    logic [15:0]                        ax_s;
    logic signed [15:0]                 ax_dc;
    logic signed [15:0]                 ax_ds;
    logic [12:0]                        ax_dim;
    logic                               ds_big;
    logic signed [16:0]                 ds_gap;
    logic [17:0]                        bound;
    logic [32:0]                        safe_lin;
    logic [34:0]                        exp_prod;
    logic signed [32:0]                 cen_prod;
    logic signed [21:0]                 cen_off;
    logic [37:0]                        size_prod;
    logic signed [24:0]                 lo_raw;
    logic signed [24:0]                 hi_raw;
    logic [17:0]                        lo_c;
    logic [17:0]                        hi_c;
    logic [19:0]                        cen_sum;
    logic [18:0]                        ext_sum;
    logic [17:0]                        cen_q;
    logic [17:0]                        ext_q;
    logic [15:0]                        cen_sat;
    logic [15:0]                        ext_sat;
    logic [16:0]                        sig_val;
    logic [adec_pkg::EXP_W-1:0]         conf_mag;

    always_comb begin
        ax_c   = r_ax ? r_job.acy : r_job.acx;
        ax_s   = r_ax ? r_job.ah  : r_job.aw;
        ax_dc  = r_ax ? r_job.dy  : r_job.dx;
        ax_ds  = r_ax ? r_job.dh  : r_job.dw;
        ax_dim = r_ax ? i_img_h   : i_img_w;
        ds_big = ax_ds > 16'sd2048;
        ds_gap = 17'sd2048 - 17'(ax_ds);
        // a zero image size clips like a size of one
        bound  = (ax_dim == 13'd0) ? 18'd0 : {ax_dim - 13'd1, 5'd0};
    end

    assign safe_lin  = 33'(adec_pkg::E_Q16) * 33'(ax_ds[14:0]);
    assign exp_prod  = 35'(adec_pkg::E_Q16) * 35'(r_e);
    assign cen_prod  = 33'(ax_dc) * $signed({17'd0, ax_s});
    assign cen_off   = 22'(cen_prod >>> 11);
    assign size_prod = 38'(ax_s) * 38'(r_safe);
    assign lo_raw    = $signed({r_cen[22], r_cen, 1'b0}) - $signed({3'd0, r_size});
    assign hi_raw    = $signed({r_cen[22], r_cen, 1'b0}) + $signed({3'd0, r_size});

    always_comb begin
        if (lo_raw < 25'sd0) begin
            lo_c = '0;
        end else if (lo_raw > $signed({7'd0, bound})) begin
            lo_c = bound;
        end else begin
            lo_c = lo_raw[17:0];
        end
        if (hi_raw < 25'sd0) begin
            hi_c = '0;
        end else if (hi_raw > $signed({7'd0, bound})) begin
            hi_c = bound;
        end else begin
            hi_c = hi_raw[17:0];
        end
    end

    assign cen_sum = 20'(r_lo) + 20'(r_hi) + 20'd32;
    assign ext_sum = 19'(r_hi) - 19'(r_lo) + 19'd32;
    assign cen_q   = cen_sum[19:2];
    assign ext_q   = ext_sum[18:1];
    assign cen_sat = (cen_q > 18'd65535) ? 16'hFFFF : cen_q[15:0];
    assign ext_sat = (ext_q > 18'd65535) ? 16'hFFFF : ext_q[15:0];

    assign o_pop    = (r_state == B_IDLE) && !i_stat.empty;
    assign sig_val  = div_quot[16:0];
    assign conf_mag = (i_job.conf < 16'sd0) ? 17'(-(17'(i_job.conf))) : 17'(i_job.conf);

    always_comb begin
        exp_start = 1'b0;
        exp_d     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (r_state)
            B_IDLE: begin
                exp_start = o_pop;
                exp_d     = conf_mag[15:0];
            end
            B_SEXP: begin
                div_start = exp_done;
                div_den   = adec_pkg::DIV_DEN_W'(adec_pkg::ONE_Q16) +
                            adec_pkg::DIV_DEN_W'(exp_res);
                if (r_job.conf < 16'sd0) begin
                    div_num = adec_pkg::DIV_NUM_W'({exp_res, 16'd0});
                end else begin
                    div_num = adec_pkg::DIV_NUM_W'(1) << 32;
                end
            end
            B_SDIV: begin
                div_start = div_done && (r_job.exp_sum != '0);
                div_num   = adec_pkg::DIV_NUM_W'({sig_val, 16'd0});
                div_den   = r_job.exp_sum;
            end
            B_AXST: begin
                exp_start = !ds_big;
                exp_d     = ds_gap[15:0];
            end
            default: begin
            end
        endcase
    end

    adec_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (exp_start),
        .i_d     (exp_d),
        .o_done  (exp_done),
        .o_res   (exp_res)
    );

    adec_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        r_state <= B_SEXP;
                    end
                end
                B_SEXP: begin
                    if (exp_done) begin
                        r_state <= B_SDIV;
                    end
                end
                B_SDIV: begin
                    if (div_done) begin
                        r_state <= (r_job.exp_sum != '0) ? B_QDIV : B_AXST;
                    end
                end
                B_QDIV: begin
                    if (div_done) begin
                        r_state <= B_AXST;
                    end
                end
                B_AXST: r_state <= ds_big ? B_AXSF : B_AXWT;
                B_AXWT: begin
                    if (exp_done) begin
                        r_state <= B_AXSF;
                    end
                end
                B_AXSF: r_state <= B_AXSZ;
                B_AXSZ: r_state <= B_AXCL;
                B_AXCL: r_state <= B_AXSV;
                B_AXSV: begin
                    if (r_ax) begin
                        r_valid <= 1'b1;
                        r_state <= B_OUT;
                    end else begin
                        r_state <= B_AXST;
                    end
                end
                B_OUT: begin
                    if (i_ready) begin
                        r_valid <= 1'b0;
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_ax  <= 1'b0;
        end
        if (r_state == B_SDIV && div_done && r_job.exp_sum == '0) begin
            r_score <= '0;
        end
        if (r_state == B_QDIV && div_done) begin
            r_score <= (div_quot > adec_pkg::DIV_NUM_W'(65535)) ? 16'hFFFF : div_quot[15:0];
        end
        if (r_state == B_AXWT && exp_done) begin
            r_e <= exp_res;
        end
        if (r_state == B_AXSF) begin
            r_safe <= ds_big ? 22'(safe_lin >> 11) : 22'(exp_prod >> 16);
            r_cen  <= $signed({7'd0, ax_c}) + 23'(cen_off);
        end
        if (r_state == B_AXSZ) begin
            r_size <= size_prod[37:16];
        end
        if (r_state == B_AXCL) begin
            r_lo <= lo_c;
            r_hi <= hi_c;
        end
        if (r_state == B_AXSV) begin
            if (r_ax) begin
                r_bcy <= cen_sat;
                r_bh  <= ext_sat;
                r_cls <= r_job.argmax;
            end else begin
                r_bcx <= cen_sat;
                r_bw  <= ext_sat;
                r_ax  <= 1'b1;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_box_cx     = r_bcx;
    assign o_box_cy     = r_bcy;
    assign o_box_w      = r_bw;
    assign o_box_h      = r_bh;
    assign o_score      = r_score;
    assign o_best_class = r_cls;
endmodule
`default_nettype wire
